// ===== rtl/core/xdm_pkg.sv =====
// xdm_pkg: shared types, constants and arithmetic helpers of the x-drive thruster mixer
// no dependencies
`timescale 1ns / 1ps
package xdm_pkg;

  localparam logic [15:0] UNIT = 16'd32768;

  // register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_DEADBAND   = 3'd0;
  localparam logic [2:0] REG_EXPO_BLEND = 3'd1;
  localparam logic [2:0] REG_TRANS_GAIN = 3'd2;
  localparam logic [2:0] REG_YAW_GAIN   = 3'd3;
  localparam logic [2:0] REG_PULSE_MIN  = 3'd4;
  localparam logic [2:0] REG_PULSE_NEUT = 3'd5;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd6;
  localparam logic [2:0] REG_INV_MASK   = 3'd7;

  // stage counts of the pipeline parts
  localparam int SHAPE_LAT = 4;
  localparam int DIV_STAGES = 8;
  localparam int NORM_LAT = DIV_STAGES + 2;
  localparam int PULSE_LAT = 3;
  localparam int TOTAL_LAT = SHAPE_LAT + 1 + NORM_LAT + PULSE_LAT;

  typedef logic signed [16:0] mix_t;
  typedef logic signed [17:0] wide_mix_t;

  typedef struct packed {
    logic [11:0] pmin;
    logic [11:0] neutral;
    logic [11:0] pmax;
    logic [3:0]  inv;
  } pulse_cfg_t;

  function automatic logic [15:0] sat_unit(input logic [15:0] v);
    sat_unit = (v > UNIT) ? UNIT : v;
  endfunction

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [17:0] div_step(input logic [16:0] r, input logic [16:0] p,
                                           input logic dbl);
    logic [17:0] t;
    logic [17:0] d;
    t = dbl ? {r, 1'b0} : {1'b0, r};
    d = t - {1'b0, p};
    if (t >= {1'b0, p}) begin
      div_step = {1'b1, d[16:0]};
    end else begin
      div_step = {1'b0, t[16:0]};
    end
  endfunction

endpackage

// ===== rtl/core/xdm_shaper.sv =====
// xdm_shaper: four-stage deadband, cubic expo and gain for one axis
// depends on xdm_pkg
`timescale 1ns / 1ps
module xdm_shaper (
  input  logic              clk,
  input  logic              en,
  input  logic [15:0]       raw,
  input  logic [15:0]       deadband,
  input  logic [15:0]       expo,
  input  logic [15:0]       gain,
  output xdm_pkg::mix_t     axis
);

  logic signed [16:0] v;
  logic [16:0] mag;
  logic [15:0] m0;

  logic [15:0] s1_m;
  logic        s1_neg;
  logic        s1_dead;
  logic [31:0] s1_mm;

  logic [47:0] cube_p;
  logic [15:0] s2_m;
  logic [15:0] s2_cube;
  logic        s2_neg;
  logic        s2_dead;

  logic [15:0] e;
  logic [15:0] ome;
  logic [31:0] blend;
  logic [15:0] s3_shaped;
  logic        s3_neg;
  logic        s3_dead;

  logic [31:0] gprod;
  logic [15:0] sc;

  assign v   = {raw[15], raw};
  assign mag = raw[15] ? 17'(-v) : 17'(v);
  assign m0  = mag[15:0];

  assign cube_p = 48'(s1_mm) * 48'(s1_m);
  assign e      = xdm_pkg::sat_unit(expo);
  assign ome    = 16'(17'd32768 - 17'(e));
  assign blend  = 32'(ome) * 32'(s2_m) + 32'(e) * 32'(s2_cube);
  assign gprod  = 32'(s3_shaped) * 32'(xdm_pkg::sat_unit(gain));
  assign sc     = gprod[30:15];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m      <= m0;
      s1_neg    <= raw[15];
      s1_dead   <= m0 < deadband;
      s1_mm     <= 32'(m0) * 32'(m0);
      s2_m      <= s1_m;
      s2_cube   <= cube_p[45:30];
      s2_neg    <= s1_neg;
      s2_dead   <= s1_dead;
      s3_shaped <= blend[30:15];
      s3_neg    <= s2_neg;
      s3_dead   <= s2_dead;
      if (s3_dead) begin
        axis <= '0;
      end else if (s3_neg) begin
        axis <= -$signed({1'b0, sc});
      end else begin
        axis <= $signed({1'b0, sc});
      end
    end
  end

endmodule

// ===== rtl/core/xdm_norm.sv =====
// xdm_norm: peak search and pipelined restoring divide that scales four mixes to one when their peak exceeds one
// depends on xdm_pkg
`timescale 1ns / 1ps
module xdm_norm (
  input  logic                   clk,
  input  logic                   en,
  input  xdm_pkg::wide_mix_t     mix_in [4],
  output xdm_pkg::mix_t          mix_out [4]
);

  localparam int NS = xdm_pkg::DIV_STAGES;

  logic [16:0] amag [4];
  logic [16:0] pk01;
  logic [16:0] pk23;
  logic [16:0] pk_all;

  logic [16:0] rem [NS+1][4];
  logic [15:0] qt  [NS+1][4];
  logic        sg  [NS+1][4];
  xdm_pkg::mix_t mx [NS+1][4];
  logic [16:0] pk  [NS+1];
  logic        byp [NS+1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      amag[l] = mix_in[l][17] ? 17'(-mix_in[l]) : 17'(mix_in[l]);
    end
  end

  assign pk01   = (amag[0] > amag[1]) ? amag[0] : amag[1];
  assign pk23   = (amag[2] > amag[3]) ? amag[2] : amag[3];
  assign pk_all = (pk01 > pk23) ? pk01 : pk23;

  // peak stage
  always_ff @(posedge clk) begin
    if (en) begin
      pk[0]  <= pk_all;
      byp[0] <= pk_all <= 17'(xdm_pkg::UNIT);
      for (int l = 0; l < 4; l++) begin
        rem[0][l] <= amag[l];
        qt[0][l]  <= '0;
        sg[0][l]  <= mix_in[l][17];
        mx[0][l]  <= mix_in[l][16:0];
      end
    end
  end

  // two quotient bits per stage, msb first; the very first step only compares
  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [17:0] st_a [4];
    logic [17:0] st_b [4];
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        st_a[l] = xdm_pkg::div_step(rem[s][l], pk[s], s != 0);
        st_b[l] = xdm_pkg::div_step(st_a[l][16:0], pk[s], 1'b1);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pk[s+1]  <= pk[s];
        byp[s+1] <= byp[s];
        for (int l = 0; l < 4; l++) begin
          rem[s+1][l] <= st_b[l][16:0];
          qt[s+1][l]  <= {qt[s][l][13:0], st_a[l][17], st_b[l][17]};
          sg[s+1][l]  <= sg[s][l];
          mx[s+1][l]  <= mx[s][l];
        end
      end
    end
  end

  // select stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        if (byp[NS]) begin
          mix_out[l] <= mx[NS][l];
        end else if (sg[NS][l]) begin
          mix_out[l] <= -$signed({1'b0, qt[NS][l]});
        end else begin
          mix_out[l] <= $signed({1'b0, qt[NS][l]});
        end
      end
    end
  end

endmodule

// ===== rtl/core/xdm_pulse.sv =====
// xdm_pulse: three-stage conversion of four mixes to esc pulse widths
// depends on xdm_pkg
`timescale 1ns / 1ps
module xdm_pulse (
  input  logic                clk,
  input  logic                en,
  input  xdm_pkg::pulse_cfg_t cfg,
  input  logic                stop_in,
  input  xdm_pkg::mix_t       mix_in [4],
  output xdm_pkg::mix_t       mix_out [4],
  output logic [11:0]         us_out [4],
  output logic                stop_out
);

  logic signed [12:0] span_pos;
  logic signed [12:0] span_neg;

  logic        p1_stop;
  logic [15:0] p1_an [4];
  logic [11:0] p1_as [4];
  logic        p1_sg [4];
  xdm_pkg::mix_t p1_mix [4];

  logic        p2_stop;
  logic [11:0] p2_q [4];
  logic        p2_sg [4];
  xdm_pkg::mix_t p2_mix [4];

  assign span_pos = $signed({1'b0, cfg.pmax}) - $signed({1'b0, cfg.neutral});
  assign span_neg = $signed({1'b0, cfg.neutral}) - $signed({1'b0, cfg.pmin});

  always_ff @(posedge clk) begin
    logic signed [16:0] n;
    logic [16:0] an;
    logic signed [12:0] sp;
    logic [12:0] asp;
    logic [27:0] prod;
    logic signed [13:0] p;
    if (en) begin
      p1_stop <= stop_in;
      p2_stop <= p1_stop;
      stop_out <= p2_stop;
      for (int l = 0; l < 4; l++) begin
        n   = cfg.inv[l] ? -mix_in[l] : mix_in[l];
        an  = n[16] ? 17'(-n) : 17'(n);
        sp  = n[16] ? span_neg : span_pos;
        asp = sp[12] ? 13'(-sp) : 13'(sp);
        p1_an[l]  <= an[15:0];
        p1_as[l]  <= asp[11:0];
        p1_sg[l]  <= n[16] ^ sp[12];
        p1_mix[l] <= mix_in[l];

        prod = 28'(p1_an[l]) * 28'(p1_as[l]);
        p2_q[l]   <= prod[26:15];
        p2_sg[l]  <= p1_sg[l];
        p2_mix[l] <= p1_mix[l];

        p = p2_sg[l] ? $signed({2'b0, cfg.neutral}) - $signed({2'b0, p2_q[l]})
                     : $signed({2'b0, cfg.neutral}) + $signed({2'b0, p2_q[l]});
        if (p2_stop) begin
          us_out[l] <= cfg.neutral;
        end else if (p < 0) begin
          us_out[l] <= '0;
        end else if (p > 14'sd4095) begin
          us_out[l] <= 12'hfff;
        end else begin
          us_out[l] <= p[11:0];
        end
        mix_out[l] <= p2_mix[l];
      end
    end
  end

endmodule

// ===== rtl/core/xdrive_thruster_mixer.sv =====
// xdrive_thruster_mixer: top level, config registers, axis shaping, x-drive mix, normalize, pulses
// depends on xdm_pkg, xdm_shaper, xdm_norm, xdm_pulse
`timescale 1ns / 1ps
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tdata strafe, surge, yaw, age; tuser drive_enable
// m_*       out  m_tvalid / m_tready     tdata four pulse widths, four mixes; tuser stopped
// apb       in   psel, penable, pready   eight config registers at 4*index
//
// one item enters per cycle unless the pipeline holds; an item passes the shaping stages, the mix
// stage, the normalizing divider (16-bit quotient, two bits per stage) and the pulse stages
// rst clears valid bits and loads register defaults
// the whole pipeline holds while the output register is full and m_tready is low
module xdrive_thruster_mixer #(
  parameter int COMMAND_TIMEOUT = 500
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // strafe_cmd, surge_cmd, yaw_cmd, command_age_ms
  input  logic         s_tuser,   // drive_enable
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // front_left_us, front_right_us, rear_left_us, rear_right_us,
                                  // front_left_mix, front_right_mix, rear_left_mix,
                                  // rear_right_mix, zero pad
  output logic         m_tuser,   // motors_stopped
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LAT = xdm_pkg::TOTAL_LAT;
  localparam int MIX_IDX = xdm_pkg::SHAPE_LAT;          // stage holding the raw mixes
  localparam int NORM_IDX = MIX_IDX + xdm_pkg::NORM_LAT; // stage holding normalized mixes

  // config registers
  logic [15:0] deadband;
  logic [15:0] expo_blend;
  logic [15:0] translation_gain;
  logic [15:0] yaw_gain;
  logic [11:0] pulse_min_us;
  logic [11:0] pulse_neutral_us;
  logic [11:0] pulse_max_us;
  logic [3:0]  invert_mask;

  logic cfg_wr;

  // pipeline control
  logic en;
  logic [LAT-1:0] vld;
  logic [NORM_IDX:0] stop_pipe;  // stopped flag per stage up to the pulse unit input
  logic stopped_in;

  xdm_pkg::mix_t sx;
  xdm_pkg::mix_t sy;
  xdm_pkg::mix_t yw;
  xdm_pkg::wide_mix_t mixes [4];
  xdm_pkg::mix_t norm_mix [4];
  xdm_pkg::mix_t out_mix [4];
  logic [11:0] out_us [4];
  xdm_pkg::pulse_cfg_t pcfg;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband         <= 16'd1638;
      expo_blend       <= 16'd9830;
      translation_gain <= 16'd32768;
      yaw_gain         <= 16'd32768;
      pulse_min_us     <= 12'd1100;
      pulse_neutral_us <= 12'd1500;
      pulse_max_us     <= 12'd1900;
      invert_mask      <= 4'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        xdm_pkg::REG_DEADBAND:   deadband         <= pwdata[15:0];
        xdm_pkg::REG_EXPO_BLEND: expo_blend       <= pwdata[15:0];
        xdm_pkg::REG_TRANS_GAIN: translation_gain <= pwdata[15:0];
        xdm_pkg::REG_YAW_GAIN:   yaw_gain         <= pwdata[15:0];
        xdm_pkg::REG_PULSE_MIN:  pulse_min_us     <= pwdata[11:0];
        xdm_pkg::REG_PULSE_NEUT: pulse_neutral_us <= pwdata[11:0];
        xdm_pkg::REG_PULSE_MAX:  pulse_max_us     <= pwdata[11:0];
        xdm_pkg::REG_INV_MASK:   invert_mask      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      xdm_pkg::REG_DEADBAND:   prdata = 32'(deadband);
      xdm_pkg::REG_EXPO_BLEND: prdata = 32'(expo_blend);
      xdm_pkg::REG_TRANS_GAIN: prdata = 32'(translation_gain);
      xdm_pkg::REG_YAW_GAIN:   prdata = 32'(yaw_gain);
      xdm_pkg::REG_PULSE_MIN:  prdata = 32'(pulse_min_us);
      xdm_pkg::REG_PULSE_NEUT: prdata = 32'(pulse_neutral_us);
      xdm_pkg::REG_PULSE_MAX:  prdata = 32'(pulse_max_us);
      xdm_pkg::REG_INV_MASK:   prdata = 32'(invert_mask);
      default:                 prdata = '0;
    endcase
  end

  // global advance: move when the output slot is empty or being drained
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  // disabled or stale command stops all thrusters
  assign stopped_in = !s_tuser || (s_tdata[63:48] > 16'(COMMAND_TIMEOUT));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stop_pipe <= {stop_pipe[NORM_IDX-1:0], stopped_in};
    end
  end

  // per-axis shaping, four stages
  xdm_shaper u_strafe (
    .clk(clk), .en(en), .raw(s_tdata[15:0]), .deadband(deadband), .expo(expo_blend),
    .gain(translation_gain), .axis(sx)
  );
  xdm_shaper u_surge (
    .clk(clk), .en(en), .raw(s_tdata[31:16]), .deadband(deadband), .expo(expo_blend),
    .gain(translation_gain), .axis(sy)
  );
  xdm_shaper u_yaw (
    .clk(clk), .en(en), .raw(s_tdata[47:32]), .deadband(deadband), .expo(expo_blend),
    .gain(yaw_gain), .axis(yw)
  );

  // x-drive mix, forced to zero when stopped
  always_ff @(posedge clk) begin
    xdm_pkg::wide_mix_t a;
    xdm_pkg::wide_mix_t b;
    xdm_pkg::wide_mix_t c;
    if (en) begin
      a = 18'(sx);
      b = 18'(sy);
      c = 18'(yw);
      if (stop_pipe[MIX_IDX-1]) begin
        for (int l = 0; l < 4; l++) mixes[l] <= '0;
      end else begin
        mixes[0] <= b + a + c;
        mixes[1] <= b - a - c;
        mixes[2] <= b - a + c;
        mixes[3] <= b + a - c;
      end
    end
  end

  // peak search and divide back to unit range
  xdm_norm u_norm (
    .clk(clk), .en(en), .mix_in(mixes), .mix_out(norm_mix)
  );

  assign pcfg = '{pmin: pulse_min_us, neutral: pulse_neutral_us, pmax: pulse_max_us,
                  inv: invert_mask};

  // stop flag taken from the stage that lines up with the normalized mixes
  xdm_pulse u_pulse (
    .clk(clk), .en(en), .cfg(pcfg), .stop_in(stop_pipe[NORM_IDX]), .mix_in(norm_mix),
    .mix_out(out_mix), .us_out(out_us), .stop_out(m_tuser)
  );

  assign m_tdata = {4'b0, out_mix[3], out_mix[2], out_mix[1], out_mix[0],
                    out_us[3], out_us[2], out_us[1], out_us[0]};

endmodule

// ===== tb/xdrive_thruster_mixer_tb.sv =====
// xdrive_thruster_mixer_tb: self-checking testbench of the x-drive thruster mixer
// depends on xdm_pkg and xdrive_thruster_mixer; predicts each result item and checks it in order
`timescale 1ns / 1ps

// holds the expected result items and checks received ones against them
class mixer_scoreboard;
  logic [120:0] pending[$];
  int errors;
  int mismatches;

  function new();
    errors = 0;
    mismatches = 0;
  endfunction

  function void note_item(logic [120:0] exp_item);
    pending.push_back(exp_item);
  endfunction

  function void check_result(logic [119:0] data, logic stopped);
    logic [120:0] exp_item;
    if (pending.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", data);
      return;
    end
    exp_item = pending.pop_front();
    if (exp_item[119:0] !== data || exp_item[120] !== stopped) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h stop %b, got %h stop %b",
                 exp_item[119:0], exp_item[120], data, stopped);
    end
  endfunction
endclass

module xdrive_thruster_mixer_tb;

  localparam int TIMEOUT_MS = 500;
  localparam int DRAIN_CYCLES = 40;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // strafe, surge, yaw, age from the lowest bit up
  logic         s_tuser = 1'b0; // drive_enable
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;        // four pulses (12 each), four mixes (17 each), pad
  logic         m_tuser;        // motors_stopped
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // shadow copy of the registers
  logic [15:0] deadband_r, blend_r, tgain_r, ygain_r;
  logic [11:0] pmin_r, pneut_r, pmax_r;
  logic [3:0]  inv_r;

  // receiver behavior control
  bit long_hold = 0;

  mixer_scoreboard board;

  xdrive_thruster_mixer #(.COMMAND_TIMEOUT(TIMEOUT_MS)) DUT (.*);

  always #2 clk = ~clk;

  // safety limit: far above the slowest run of ~800 items with full gaps
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // clamp, deadband, expo blend and gain on one axis; truncation toward zero
  function automatic longint shape_axis_of(logic [15:0] raw, logic [15:0] gain);
    longint v, m, e, g, cube, shaped, scaled;
    v = longint'($signed(raw));
    m = v < 0 ? -v : v;
    e = blend_r > xdm_pkg::UNIT ? 32768 : blend_r;
    g = gain > xdm_pkg::UNIT ? 32768 : gain;
    if (m < deadband_r) return 0;
    cube = (m * m * m) >>> 30;
    shaped = ((32768 - e) * m + e * cube) >>> 15;
    scaled = (shaped * g) >>> 15;
    return v < 0 ? -scaled : scaled;
  endfunction

  // asymmetric pulse scaling, saturated to 12 bits
  function automatic logic [11:0] pulse_of(longint n);
    longint neu, span, p;
    neu = pneut_r;
    span = n >= 0 ? longint'(pmax_r) - neu : neu - longint'(pmin_r);
    p = neu + (n * span) / 32768;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p[11:0];
  endfunction

  // full prediction of one result item: {stopped, tdata}
  function automatic logic [120:0] mixer_result(logic [63:0] d, logic en);
    longint sx, sy, yw, peak, a, n;
    longint mix[4];
    logic [120:0] r;
    bit stopped;
    stopped = !en || d[63:48] > TIMEOUT_MS;
    r = '0;
    for (int i = 0; i < 4; i++) mix[i] = 0;
    if (!stopped) begin
      sx = shape_axis_of(d[15:0], tgain_r);
      sy = shape_axis_of(d[31:16], tgain_r);
      yw = shape_axis_of(d[47:32], ygain_r);
      mix[0] = sy + sx + yw;
      mix[1] = sy - sx - yw;
      mix[2] = sy - sx + yw;
      mix[3] = sy + sx - yw;
      peak = 0;
      for (int i = 0; i < 4; i++) begin
        a = mix[i] < 0 ? -mix[i] : mix[i];
        if (a > peak) peak = a;
      end
      if (peak > 32768)
        for (int i = 0; i < 4; i++) mix[i] = (mix[i] * 32768) / peak;
    end
    for (int i = 0; i < 4; i++) begin
      n = inv_r[i] ? -mix[i] : mix[i];
      r[12*i +: 12] = stopped ? pneut_r : pulse_of(n);
      r[48 + 17*i +: 17] = mix[i][16:0];
    end
    r[120] = stopped;
    return r;
  endfunction

  // apb write: setup then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      xdm_pkg::REG_DEADBAND:   deadband_r = val[15:0];
      xdm_pkg::REG_EXPO_BLEND: blend_r = val[15:0];
      xdm_pkg::REG_TRANS_GAIN: tgain_r = val[15:0];
      xdm_pkg::REG_YAW_GAIN:   ygain_r = val[15:0];
      xdm_pkg::REG_PULSE_MIN:  pmin_r = val[11:0];
      xdm_pkg::REG_PULSE_NEUT: pneut_r = val[11:0];
      xdm_pkg::REG_PULSE_MAX:  pmax_r = val[11:0];
      xdm_pkg::REG_INV_MASK:   inv_r = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] db, logic [15:0] bl, logic [15:0] tg, logic [15:0] yg,
                           logic [11:0] pn, logic [11:0] pu, logic [11:0] px, logic [3:0] iv);
    write_reg(xdm_pkg::REG_DEADBAND, 32'(db));
    write_reg(xdm_pkg::REG_EXPO_BLEND, 32'(bl));
    write_reg(xdm_pkg::REG_TRANS_GAIN, 32'(tg));
    write_reg(xdm_pkg::REG_YAW_GAIN, 32'(yg));
    write_reg(xdm_pkg::REG_PULSE_MIN, 32'(pn));
    write_reg(xdm_pkg::REG_PULSE_NEUT, 32'(pu));
    write_reg(xdm_pkg::REG_PULSE_MAX, 32'(px));
    write_reg(xdm_pkg::REG_INV_MASK, 32'(iv));
  endtask

  // offer one command item after a random gap, note its prediction on acceptance
  // valid stays high after acceptance so that the next item can follow directly
  task automatic send_cmd(logic [15:0] sx, logic [15:0] sy, logic [15:0] yw,
                          logic [15:0] age, logic en, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {age, yw, sy, sx};
    s_tuser <= en;
    do @(posedge clk); while (!s_tready);
    board.note_item(mixer_result({age, yw, sy, sx}, en));
  endtask

  // stop offering, wait for every expected item, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 3000));
      4: return -16'($urandom_range(0, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_age();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'($urandom_range(495, 505));
      default: return 16'($urandom_range(0, 500));
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_cmd(rand_axis(), rand_axis(), rand_axis(), rand_age(), $urandom_range(0, 9) != 0);
  endtask

  // receiver: random ready with gaps, plus one long hold-off on request
  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // result checker, sampled at the clock edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
  end

  initial begin
    board = new();
    deadband_r = 16'd1638; blend_r = 16'd9830; tgain_r = 16'd32768; ygain_r = 16'd32768;
    pmin_r = 12'd1100; pneut_r = 12'd1500; pmax_r = 12'd1900; inv_r = 4'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, stop cases, timeout edge, deadband edge under reset registers
    send_cmd(16'h8000, 16'h8000, 16'h8000, 16'd0, 1'b1);
    send_cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 1'b1);
    send_cmd(16'h7fff, 16'h8000, 16'h7fff, 16'd500, 1'b1);
    send_cmd(16'h7fff, 16'h7fff, 16'h0000, 16'd501, 1'b1);
    send_cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 1'b0);
    send_cmd(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_cmd(16'd1637, 16'd1638, -16'd1638, 16'd100, 1'b1);
    send_cmd(16'h0000, 16'h4000, 16'hc000, 16'd1, 1'b1);
    drain();

    // extremes of the registers: blend and gain above one, deadband above one, inverted
    write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'd500, 12'd2500, 12'd500, 4'hf);
    send_cmd(16'h7fff, 16'h8000, 16'h1234, 16'd0, 1'b1);
    send_cmd(16'h8000, 16'h8000, 16'h8000, 16'd0, 1'b1);
    drain();
    write_all(16'd0, 16'd32768, 16'd32768, 16'hffff, 12'd2500, 12'd500, 12'd4095, 4'h5);
    send_cmd(16'h8000, 16'h7fff, 16'h8000, 16'd0, 1'b1);
    send_cmd(16'h0001, 16'hffff, 16'h0000, 16'd0, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'hc000, 16'd0, 1'b1);
    random_phase(100);
    drain();

    // long receiver hold with the sender pushing back to back
    write_all(16'd0, 16'd0, 16'd20000, 16'd30000, 12'd1000, 12'd1500, 12'd2000, 4'ha);
    long_hold = 1;
    for (int i = 0; i < 60; i++)
      send_cmd(rand_axis(), rand_axis(), rand_axis(), rand_age(), 1'b1, 1);
    random_phase(100);
    drain();

    // several random register settings
    for (int p = 0; p < 5; p++) begin
      write_all(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 32768)),
                16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                12'($urandom_range(500, 2500)), 12'($urandom_range(500, 2500)),
                12'($urandom_range(500, 2500)), 4'($urandom));
      random_phase(100);
      drain();
    end
    write_all(16'd1638, 16'd9830, 16'd32768, 16'd32768, 12'd1100, 12'd1500, 12'd1900, 4'h0);
    random_phase(30);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
